// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/stc_pkg.sv
// Package for the stencil threshold counter: widths, defaults and register codes.
package stc_pkg;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int COUNT_W   = 20;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_MAX_ROWS    = 1024;
  localparam int DEF_PIXEL_BITS  = 8;

  localparam logic [CFG_W-1:0] RST_FRAME_COLUMNS = 11'd16;
  localparam logic [CFG_W-1:0] RST_FRAME_ROWS    = 11'd16;
  localparam logic [CFG_W-1:0] RST_SUM_THRESHOLD = 11'd30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_COLUMNS = 2'd0,
    CFG_FRAME_ROWS    = 2'd1,
    CFG_SUM_THRESHOLD = 2'd2
  } cfg_reg_e;

endpackage

// File: rtl/core/stencil_threshold_counter.sv
// Five-point stencil threshold counter: top level.
//
// Pixels enter in raster order on the input channel (in_valid_i / in_stall_o,
// pixel_value_i), one word per cycle. For each interior pixel of the frame the
// cross of it and its four neighbors is summed; a sum above sum_threshold adds
// one to a saturating 20-bit count. When the last pixel of a frame is taken,
// one word carrying the count leaves on the output channel
// (out_valid_o / out_stall_i, star_count_o) and the count restarts at zero.
// The last pixel is registered in stage 1, then the count word in the output register.
// Throughput: one pixel per cycle; the two line buffers take one read and one
// write each per pixel. The input stalls only while a finished count waits in
// the output register and a second frame end is already queued behind it.
// Configuration (cfg_valid_i / cfg_ready_o, always ready) sets frame columns,
// frame rows and the threshold; write it between frames.
// Reset clears position, window and count, and restores the register defaults
// (16 x 16 frame, threshold 30). Line buffers need no clearing.
module stencil_threshold_counter
  import stc_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int PIXEL_BITS  = DEF_PIXEL_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIXEL_BITS-1:0] pixel_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COUNT_W-1:0]    star_count_o
);

  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CSZ_W  = $clog2(MAX_COLUMNS + 1);
  localparam int RSZ_W  = $clog2(MAX_ROWS + 1);
  localparam int CCMP_W = (CSZ_W > CFG_W) ? CSZ_W : CFG_W;
  localparam int RCMP_W = (RSZ_W > CFG_W) ? RSZ_W : CFG_W;
  localparam int SUM_W  = PIXEL_BITS + 3;
  localparam int THR_W  = (SUM_W > CFG_W) ? SUM_W : CFG_W;

  // configuration
  logic [CFG_W-1:0] cols_cfg_q, rows_cfg_q, thr_q;
  logic [CSZ_W-1:0] cols_eff;
  logic [RSZ_W-1:0] rows_eff;

  // position
  logic [COL_W-1:0] col_q, col_d, up_addr;
  logic [ROW_W-1:0] row_q, row_d;
  logic             last_col, last_row, interior;

  // stage 1
  logic                  s1_valid_q, s1_valid_d;
  logic [PIXEL_BITS-1:0] s1_pix_q;
  logic                  s1_interior_q, s1_end_q;
  logic [COL_W-1:0]      s1_col_q;
  logic [PIXEL_BITS-1:0] right_q, up_q;

  // window
  logic [PIXEL_BITS-1:0] left_q, centre_q, prev_pix_q;

  // line buffers
  logic [PIXEL_BITS-1:0] newer_mem [MAX_COLUMNS];
  logic [PIXEL_BITS-1:0] older_mem [MAX_COLUMNS];

  // count and output
  logic [SUM_W-1:0]   sum;
  logic               over, count_inc;
  logic [COUNT_W-1:0] count_q, count_d, count_new;
  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] out_count_q;

  logic hold, advance, in_acc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= RST_FRAME_COLUMNS;
      rows_cfg_q <= RST_FRAME_ROWS;
      thr_q      <= RST_SUM_THRESHOLD;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_FRAME_COLUMNS: cols_cfg_q <= cfg_data_i;
        CFG_FRAME_ROWS:    rows_cfg_q <= cfg_data_i;
        CFG_SUM_THRESHOLD: thr_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // frame size: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (cols_cfg_q == '0) begin
      cols_eff = CSZ_W'(1);
    end else if (CCMP_W'(cols_cfg_q) > CCMP_W'(MAX_COLUMNS)) begin
      cols_eff = CSZ_W'(MAX_COLUMNS);
    end else begin
      cols_eff = CSZ_W'(cols_cfg_q);
    end
    if (rows_cfg_q == '0) begin
      rows_eff = RSZ_W'(1);
    end else if (RCMP_W'(rows_cfg_q) > RCMP_W'(MAX_ROWS)) begin
      rows_eff = RSZ_W'(MAX_ROWS);
    end else begin
      rows_eff = RSZ_W'(rows_cfg_q);
    end
  end

  // handshake
  assign hold       = s1_valid_q && s1_end_q && out_valid_q && out_stall_i;
  assign advance    = s1_valid_q && !hold;
  assign in_acc     = in_valid_i && !hold;
  assign in_stall_o = hold;
  assign s1_valid_d = in_acc || hold;

  // position of the incoming pixel; the stencil centre is one row up, one left
  always_comb begin
    last_col = (CSZ_W'(col_q) + CSZ_W'(1)) >= cols_eff;
    last_row = (RSZ_W'(row_q) + RSZ_W'(1)) >= rows_eff;
    interior = (col_q >= COL_W'(2)) && (CSZ_W'(col_q) < cols_eff) &&
               (row_q >= ROW_W'(2)) && (RSZ_W'(row_q) < rows_eff);
    up_addr  = (col_q == '0) ? '0 : col_q - COL_W'(1);
    col_d    = col_q;
    row_d    = row_q;
    if (in_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_col_q   <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      if (in_acc) begin
        s1_col_q <= col_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q      <= pixel_value_i;
      s1_interior_q <= interior;
      s1_end_q      <= last_col && last_row;
    end
  end

  // Newer line takes each pixel at once; the value it replaces moves to the
  // older line one word later. Reads return the contents before the write.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      right_q             <= newer_mem[col_q];
      up_q                <= older_mem[up_addr];
      newer_mem[col_q]    <= pixel_value_i;
      older_mem[s1_col_q] <= right_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q     <= '0;
      centre_q   <= '0;
      prev_pix_q <= '0;
    end else if (advance) begin
      left_q     <= centre_q;
      centre_q   <= right_q;
      prev_pix_q <= s1_pix_q;
    end
  end

  always_comb begin
    sum = SUM_W'(centre_q) + SUM_W'(up_q) + SUM_W'(prev_pix_q) +
          SUM_W'(left_q) + SUM_W'(right_q);
    over      = THR_W'(sum) > THR_W'(thr_q);
    count_inc = s1_interior_q && over && (count_q != COUNT_MAX);
    count_new = count_q + COUNT_W'(count_inc);
    count_d   = count_q;
    if (advance) begin
      count_d = s1_end_q ? '0 : count_new;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (advance && s1_end_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_end_q) begin
      out_count_q <= count_new;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign star_count_o = out_count_q;

endmodule

// File: rtl/core/stc_checker.sv
// Port-level checker for the stencil threshold counter, bound to the top level.
`include "assert_macros.svh"

module stc_checker
  import stc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [COUNT_W-1:0] star_count_o
);

  // a stalled result word holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(star_count_o))

  // input backpressure only comes from a stalled output
  `ASSERT_IMPL(a_no_stall_when_out_free, clk_i, rst_ni, !out_stall_i, !in_stall_o)

  `ASSERT_IMPL(a_stall_needs_result, clk_i, rst_ni, in_stall_o, out_valid_o)

  // a fresh result follows an accepted input pixel
  `ASSERT_IMPL(a_result_latency, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && !in_stall_o, 2))

endmodule

bind stencil_threshold_counter stc_checker u_stc_checker (.*);

// File: bench/tb.sv
// Testbench for stencil_threshold_counter: random and corner frames checked against a predictor.
`timescale 1ns / 1ps

module tb;
  import stc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PIX_W          = DEF_PIXEL_BITS;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index   = CFG_FRAME_COLUMNS;
  logic [CFG_W-1:0]     cfg_data    = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall_o;
  logic [PIX_W-1:0]     pixel_value = '0;
  logic                 out_valid_o;
  logic                 out_stall   = 1'b0;
  logic [COUNT_W-1:0]   star_count_o;

  stencil_threshold_counter uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .pixel_value_i(pixel_value),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .star_count_o (star_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [CFG_W-1:0]   cfg_cols = RST_FRAME_COLUMNS;
  logic [CFG_W-1:0]   cfg_rows = RST_FRAME_ROWS;
  logic [CFG_W-1:0]   cfg_thr  = RST_SUM_THRESHOLD;
  logic [PIX_W-1:0]   older_row [DEF_MAX_COLUMNS];
  logic [PIX_W-1:0]   newer_row [DEF_MAX_COLUMNS];
  logic [PIX_W-1:0]   win_left   = '0;
  logic [PIX_W-1:0]   win_center = '0;
  logic [PIX_W-1:0]   prev_pixel = '0;
  int                 col_pos    = 0;
  int                 row_pos    = 0;
  logic [COUNT_W-1:0] star_total = '0;

  logic [COUNT_W-1:0] expected_counts [$];
  int mismatch_count = 0;
  int pixels_sent    = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int stall_hold     = 0;
  int quiet_cycles   = 0;

  initial begin
    for (int i = 0; i < DEF_MAX_COLUMNS; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
  end

  function automatic int clamp_size(input logic [CFG_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic int frame_pixels();
    return clamp_size(cfg_cols, DEF_MAX_COLUMNS) * clamp_size(cfg_rows, DEF_MAX_ROWS);
  endfunction

  // Cross centered one row up and one column left of the incoming pixel.
  function automatic void predict_pixel(input logic [PIX_W-1:0] pix, output bit frame_end,
                                        output logic [COUNT_W-1:0] count);
    int cols;
    int rows;
    int c;
    int r;
    int up;
    int right;
    int sum;
    cols = clamp_size(cfg_cols, DEF_MAX_COLUMNS);
    rows = clamp_size(cfg_rows, DEF_MAX_ROWS);
    c = col_pos;
    r = row_pos;
    right = int'(newer_row[c]);
    frame_end = 1'b0;
    count = '0;
    if (c >= 1) begin
      up = int'(older_row[c-1]);
      if (c >= 2 && c + 1 <= cols && r >= 2 && r + 1 <= rows) begin
        sum = int'(win_center) + up + int'(prev_pixel) + int'(win_left) + right;
        if (sum > int'(cfg_thr) && star_total < COUNT_MAX) star_total = star_total + 1'b1;
      end
      older_row[c-1] = newer_row[c-1];
      newer_row[c-1] = prev_pixel;
    end
    if (c + 1 >= cols) begin
      older_row[c] = right[PIX_W-1:0];
      newer_row[c] = pix;
    end
    win_left   = win_center;
    win_center = right[PIX_W-1:0];
    prev_pixel = pix;
    if (c + 1 < cols) begin
      col_pos = c + 1;
    end else begin
      col_pos = 0;
      if (r + 1 < rows) begin
        row_pos = r + 1;
      end else begin
        row_pos    = 0;
        frame_end  = 1'b1;
        count      = star_total;
        star_total = '0;
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Count word checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected count word %0d", star_count_o));
      end else begin
        if (star_count_o !== expected_counts[0])
          report_mismatch($sformatf("star_count %0d, expected %0d",
                                    star_count_o, expected_counts[0]));
        void'(expected_counts.pop_front());
      end
    end
  end

  // Output stall driver; stall_hold forces a long hold-off
  always @(posedge clk_i) begin
    if (stall_hold > 0) begin
      stall_hold = stall_hold - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    bit frame_end;
    logic [COUNT_W-1:0] count;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    pixel_value <= pix;
    do @(posedge clk_i); while (in_stall_o);
    pixels_sent++;
    predict_pixel(pix, frame_end, count);
    if (frame_end) expected_counts.push_back(count);
  endtask

  task automatic send_frame(input int lo, input int hi);
    int n;
    n = frame_pixels();
    repeat (n) send_pixel(PIX_W'($urandom_range(lo, hi)));
  endtask

  // Writes all three registers once the block has drained.
  task automatic program_frame(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows,
                               input logic [CFG_W-1:0] thr);
    logic [CFG_W-1:0] vals [3];
    cfg_reg_e         regs [3];
    vals = '{cols, rows, thr};
    regs = '{CFG_FRAME_COLUMNS, CFG_FRAME_ROWS, CFG_SUM_THRESHOLD};
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (regs[i])
        CFG_FRAME_COLUMNS: cfg_cols = vals[i];
        CFG_FRAME_ROWS:    cfg_rows = vals[i];
        CFG_SUM_THRESHOLD: cfg_thr  = vals[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_frame(0, 12);
  endtask

  task automatic test_corner_frames();
    program_frame('0, '0, '0);
    send_frame(255, 255);
    program_frame(11'd3, 11'd1, '0);
    send_frame(255, 255);
    program_frame(11'd3, 11'd3, '0);
    send_frame(255, 255);
    program_frame(11'd3, 11'd3, 11'd1275);
    send_frame(255, 255);
  endtask

  task automatic test_wide_rows();
    program_frame(11'd40, 11'd3, 11'd640);
    send_frame(0, 255);
  endtask

  task automatic test_tall_column();
    program_frame(11'd1, 11'd40, 11'h7FF);
    send_frame(0, 255);
  endtask

  // 1x1 frames end on every word, so a held output fills the block quickly.
  task automatic test_output_backpressure();
    program_frame(11'd1, 11'd1, '0);
    stall_hold = 300;
    repeat (40) send_frame(0, 255);
  endtask

  task automatic test_random_frames(input int target);
    int start;
    int hi;
    logic [CFG_W-1:0] cols;
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] thr;
    start = pixels_sent;
    while (pixels_sent - start < target) begin
      cols = CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                : $urandom_range(1, 12));
      rows = CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                : $urandom_range(1, 12));
      case ($urandom_range(0, 2))
        0:       hi = 255;
        1:       hi = 15;
        default: hi = 1;
      endcase
      thr = CFG_W'($urandom_range(0, 5 * hi + 2));
      program_frame(cols, rows, thr);
      repeat ($urandom_range(1, 3)) send_frame(0, hi);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 36;
    recv_idle_pct = 82;
    test_reset_defaults();
    test_corner_frames();
    test_wide_rows();
    test_tall_column();
    test_output_backpressure();
    test_random_frames(260);

    send_idle_pct = 82;
    recv_idle_pct = 36;
    test_random_frames(260);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(260);

    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
